[design/particle_swarm_update_engine_assert.svh]
// Assertion macros for the particle swarm update engine.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef PARTICLE_SWARM_UPDATE_ENGINE_ASSERT_SVH
`define PARTICLE_SWARM_UPDATE_ENGINE_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define PSUE_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition holds in the cycle after the trigger.
`define PSUE_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

[design/psue_pkg.sv]
// Shared types and constants of the particle swarm update engine.
// No dependencies.
`default_nettype none
package psue_pkg;

	localparam int NUM_PARTICLES_DEF = 100;
	localparam int NUM_DIMS_DEF      = 10;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_UPDATE = 2'd1,
		FUNC_SCAN   = 2'd2,
		FUNC_READ   = 2'd3
	} func_t;

	localparam logic [2:0] CFG_INERTIA   = 3'd0;
	localparam logic [2:0] CFG_COGNITIVE = 3'd1;
	localparam logic [2:0] CFG_SOCIAL    = 3'd2;
	localparam logic [2:0] CFG_VEL_LIMIT = 3'd3;
	localparam logic [2:0] CFG_TOLERANCE = 3'd4;

	localparam logic [17:0] INERTIA_RST   = 18'd45875;
	localparam logic [17:0] COGNITIVE_RST = 18'd98304;
	localparam logic [17:0] SOCIAL_RST    = 18'd98304;
	localparam logic [30:0] VEL_LIMIT_RST = 31'd32768;
	localparam logic [63:0] TOLERANCE_RST = 64'd42950;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LD,
		S_RD,
		S_M1,
		S_M2,
		S_SUM,
		S_SQ,
		S_ACC,
		S_CP_RD,
		S_CP_WR,
		S_SC_RD,
		S_SC_CMP,
		S_GC_RD,
		S_GC_WR,
		S_SC_END,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

[design/particle_swarm_update_engine.sv]
// Top level of the particle swarm update engine: stores, update datapath, scan.
// Depends on psue_pkg and particle_swarm_update_engine_assert.svh.
`default_nettype none
`include "particle_swarm_update_engine_assert.svh"
// How to use this block:
// Items enter on the item channel (item_valid, item_stall) and every item
// gives exactly one result beat on the result channel (result_valid,
// result_stall). The engine works on one item at a time; item_stall is low
// only while it is idle, and a finished result sits in an output register so
// the next item can be taken while the receiver still stalls that beat.
// Each item walks the states of its kind: a read or an out-of-range load or
// update goes straight to the result; a load writes the memories, then
// squares and accumulates; an update reads, multiplies, sums, squares and
// accumulates, then copies the position into the personal best when an
// update at the last dimension improves it. A scan compares each particle's
// best fitness in turn, then copies the global best position when the
// global best changes. Position, velocity and personal best position live in
// memories of NUM_PARTICLES*NUM_DIMS words; personal best fitness in one of
// NUM_PARTICLES words. These are undefined until loaded, and reset does not
// sweep them. Reset sets the global best to zero with fitness all ones,
// clears the fitness accumulator and loads the default configuration.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are meant for idle periods only.
module particle_swarm_update_engine
	import psue_pkg::*;
#(
	parameter int NUM_PARTICLES = NUM_PARTICLES_DEF,
	parameter int NUM_DIMS      = NUM_DIMS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [63:0]        cfg_data,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [1:0]         func,
	input  wire logic [6:0]         particle_index,
	input  wire logic [3:0]         dim_index,
	input  wire logic [15:0]        rand_cognitive,
	input  wire logic [15:0]        rand_social,
	input  wire logic signed [31:0] load_position,
	input  wire logic signed [31:0] load_velocity,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed [31:0]      value,
	output logic [63:0]             fitness,
	output logic                    improved,
	output logic                    converged
);

	localparam int ENTRIES = NUM_PARTICLES * NUM_DIMS;
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
	localparam int DW = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
	localparam int KW = $clog2(NUM_DIMS + 1);

	// Configuration registers.
	logic [17:0] inertia_q, cognitive_q, social_q;
	logic [30:0] vel_limit_q;
	logic [63:0] tolerance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inertia_q   <= INERTIA_RST;
			cognitive_q <= COGNITIVE_RST;
			social_q    <= SOCIAL_RST;
			vel_limit_q <= VEL_LIMIT_RST;
			tolerance_q <= TOLERANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INERTIA:   inertia_q   <= cfg_data[17:0];
				CFG_COGNITIVE: cognitive_q <= cfg_data[17:0];
				CFG_SOCIAL:    social_q    <= cfg_data[17:0];
				CFG_VEL_LIMIT: vel_limit_q <= cfg_data[30:0];
				CFG_TOLERANCE: tolerance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;

	// Captured item fields.
	func_t              func_q;
	logic [PW-1:0]      p_q;
	logic [DW-1:0]      d_q;
	logic [AW-1:0]      e_q;
	logic [AW-1:0]      base_q;
	logic [15:0]        r1_q, r2_q;
	logic signed [31:0] lp_q, lv_q;

	// Sequencer counters and scan state.
	logic [KW-1:0] k_q;
	logic [PW-1:0] i_q;
	logic [PW-1:0] best_q;

	// Global best and accumulator.
	logic signed [31:0] gb_q [NUM_DIMS];
	logic [63:0]        gbf_q;
	logic [63:0]        acc_q;

	// Pending result.
	logic signed [31:0] pend_val_q;
	logic [63:0]        pend_fit_q;
	logic               pend_imp_q, pend_conv_q;

	// Update pipeline.
	logic signed [31:0] pos_s1;
	logic signed [50:0] inert_prod_s1;
	logic [33:0]        g1_prod_s1, g2_prod_s1;
	logic signed [32:0] diff1_s1, diff2_s1;
	logic signed [34:0] inert_s2;
	logic signed [51:0] cog_prod_s2, soc_prod_s2;
	logic signed [31:0] newpos_q;
	logic [63:0]        sq_s3;

	// Memories.
	logic signed [31:0] pos_mem [ENTRIES];
	logic signed [31:0] vel_mem [ENTRIES];
	logic signed [31:0] pbp_mem [ENTRIES];
	logic [63:0]        pbf_mem [NUM_PARTICLES];
	logic signed [31:0] pos_rd, vel_rd, pbp_rd;
	logic [63:0]        pbf_rd;

	logic               accept;
	logic               last_dim;
	logic               in_range;
	logic               out_free;
	logic [AW-1:0]      copy_addr, gcopy_addr;
	logic [AW-1:0]      pos_raddr, pbp_raddr, pbp_waddr;
	logic [PW-1:0]      pbf_raddr;
	logic               pos_we, vel_we, pbp_we, pbf_we;
	logic signed [31:0] pos_wdata, vel_wdata, pbp_wdata;
	logic signed [37:0] vsum, vlim;
	logic signed [31:0] vclamp;
	logic signed [32:0] psum;
	logic signed [31:0] psat;
	logic [32:0]        mag;
	logic [64:0]        acc_sum;
	logic [63:0]        acc_new;
	logic               pb_better;
	logic               gb_better;

	assign accept    = item_valid && !item_stall;
	assign in_range  = (32'(particle_index) < NUM_PARTICLES) && (32'(dim_index) < NUM_DIMS);
	assign last_dim  = (32'(d_q) == NUM_DIMS - 1);
	assign out_free  = !result_valid || !result_stall;
	assign copy_addr  = base_q + AW'(k_q);
	assign gcopy_addr = AW'(32'(best_q) * NUM_DIMS) + AW'(k_q);

	// Velocity sum, clamp and position saturation.
	always_comb begin
		vsum = 38'(inert_s2) + 38'($signed(cog_prod_s2[51:16])) +
			38'($signed(soc_prod_s2[51:16]));
		vlim = $signed({7'b0, vel_limit_q});
		if (vsum > vlim) vclamp = 32'(vlim);
		else if (vsum < -vlim) vclamp = 32'(-vlim);
		else vclamp = vsum[31:0];
		psum = 33'(pos_s1) + 33'(vclamp);
		if (psum[32] != psum[31]) psat = psum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else psat = psum[31:0];
	end

	// Square magnitude and saturating accumulation.
	assign mag     = newpos_q[31] ? (33'd0 - {1'b1, newpos_q}) : {1'b0, newpos_q};
	assign acc_sum = {1'b0, acc_q} + {1'b0, sq_s3};
	assign acc_new = (d_q == '0) ? sq_s3 : (acc_sum[64] ? '1 : acc_sum[63:0]);
	assign pb_better = acc_new < pbf_rd;
	assign gb_better = pbf_rd < gbf_q;

	// Memory port selection.
	always_comb begin
		pos_raddr = (state_q == S_CP_RD) ? copy_addr : e_q;
		pbp_raddr = (state_q == S_GC_RD) ? gcopy_addr : e_q;
		pbf_raddr = (state_q == S_SC_RD) ? i_q : p_q;
		pos_we    = (state_q == S_LD) || (state_q == S_SUM);
		vel_we    = pos_we;
		pos_wdata = (state_q == S_LD) ? lp_q : psat;
		vel_wdata = (state_q == S_LD) ? lv_q : vclamp;
		pbp_we    = (state_q == S_LD) || (state_q == S_CP_WR);
		pbp_waddr = (state_q == S_LD) ? e_q : copy_addr;
		pbp_wdata = (state_q == S_LD) ? lp_q : pos_rd;
		pbf_we    = (state_q == S_ACC) && last_dim &&
			((func_q == FUNC_LOAD) || pb_better);
	end

	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[e_q] <= pos_wdata;
		pos_rd <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (vel_we) vel_mem[e_q] <= vel_wdata;
		vel_rd <= vel_mem[e_q];
	end

	always_ff @(posedge clk) begin
		if (pbp_we) pbp_mem[pbp_waddr] <= pbp_wdata;
		pbp_rd <= pbp_mem[pbp_raddr];
	end

	always_ff @(posedge clk) begin
		if (pbf_we) pbf_mem[p_q] <= acc_new;
		pbf_rd <= pbf_mem[pbf_raddr];
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Next state and the item handshake.
	always_comb begin
		state_d    = state_q;
		item_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					unique case (func_t'(func))
						FUNC_LOAD:   state_d = in_range ? S_LD : S_DONE;
						FUNC_UPDATE: state_d = in_range ? S_RD : S_DONE;
						FUNC_SCAN:   state_d = S_SC_RD;
						FUNC_READ:   state_d = S_DONE;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_LD:    state_d = S_SQ;
			S_RD:    state_d = S_M1;
			S_M1:    state_d = S_M2;
			S_M2:    state_d = S_SUM;
			S_SUM:   state_d = S_SQ;
			S_SQ:    state_d = S_ACC;
			S_ACC: begin
				if (func_q == FUNC_UPDATE && last_dim && pb_better) state_d = S_CP_RD;
				else state_d = S_DONE;
			end
			S_CP_RD: state_d = S_CP_WR;
			S_CP_WR: state_d = (32'(k_q) == NUM_DIMS - 1) ? S_DONE : S_CP_RD;
			S_SC_RD: state_d = S_SC_CMP;
			S_SC_CMP: begin
				if (32'(i_q) == NUM_PARTICLES - 1)
					state_d = (pend_imp_q || gb_better) ? S_GC_RD : S_SC_END;
				else
					state_d = S_SC_RD;
			end
			S_GC_RD: state_d = S_GC_WR;
			S_GC_WR: state_d = (32'(k_q) == NUM_DIMS - 1) ? S_SC_END : S_GC_RD;
			S_SC_END: state_d = S_DONE;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers: counters, global best, accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			i_q    <= '0;
			best_q <= '0;
			gbf_q  <= '1;
			acc_q  <= '0;
			for (int j = 0; j < NUM_DIMS; j++) gb_q[j] <= '0;
		end else begin
			if (accept) begin
				k_q <= '0;
				i_q <= '0;
			end
			if (state_q == S_ACC) acc_q <= acc_new;
			if (state_q == S_CP_WR || state_q == S_GC_WR) k_q <= k_q + KW'(1);
			if (state_q == S_SC_CMP) begin
				if (gb_better) begin
					gbf_q  <= pbf_rd;
					best_q <= i_q;
				end
				i_q <= i_q + PW'(1);
			end
			if (state_q == S_GC_WR) gb_q[k_q[DW-1:0]] <= pbp_rd;
		end
	end

	// Item capture, update pipeline and pending result.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q      <= func_t'(func);
			p_q         <= PW'(particle_index);
			d_q         <= DW'(dim_index);
			e_q         <= AW'(32'(particle_index) * NUM_DIMS + 32'(dim_index));
			base_q      <= AW'(32'(particle_index) * NUM_DIMS);
			r1_q        <= rand_cognitive;
			r2_q        <= rand_social;
			lp_q        <= load_position;
			lv_q        <= load_velocity;
			pend_fit_q  <= '0;
			pend_imp_q  <= 1'b0;
			pend_conv_q <= 1'b0;
			if (func_t'(func) == FUNC_READ && 32'(dim_index) < NUM_DIMS)
				pend_val_q <= gb_q[DW'(dim_index)];
			else
				pend_val_q <= '0;
		end
		if (state_q == S_LD) newpos_q <= lp_q;
		if (state_q == S_M1) begin
			pos_s1        <= pos_rd;
			inert_prod_s1 <= $signed({1'b0, inertia_q}) * vel_rd;
			g1_prod_s1    <= cognitive_q * r1_q;
			g2_prod_s1    <= social_q * r2_q;
			diff1_s1      <= 33'(pbp_rd) - 33'(pos_rd);
			diff2_s1      <= 33'(gb_q[d_q]) - 33'(pos_rd);
		end
		if (state_q == S_M2) begin
			inert_s2    <= inert_prod_s1[50:16];
			cog_prod_s2 <= $signed({1'b0, g1_prod_s1[33:16]}) * diff1_s1;
			soc_prod_s2 <= $signed({1'b0, g2_prod_s1[33:16]}) * diff2_s1;
		end
		if (state_q == S_SUM) begin
			newpos_q   <= psat;
			pend_val_q <= psat;
		end
		if (state_q == S_SQ) sq_s3 <= mag[31:0] * mag[31:0];
		if (state_q == S_ACC && last_dim) begin
			pend_fit_q <= acc_new;
			if (func_q == FUNC_UPDATE) pend_imp_q <= pb_better;
		end
		if (state_q == S_SC_CMP && gb_better) pend_imp_q <= 1'b1;
		if (state_q == S_SC_END) begin
			pend_fit_q  <= gbf_q;
			pend_conv_q <= gbf_q < tolerance_q;
		end
	end

	// Output register: a finished result waits here while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			value     <= pend_val_q;
			fitness   <= pend_fit_q;
			improved  <= pend_imp_q;
			converged <= pend_conv_q;
		end
	end

	`PSUE_ASSERT_NEXT(a_done_loads, (state_q == S_DONE) && out_free, result_valid,
		"finished result did not reach the output register")
	`PSUE_ASSERT_SAME(a_copy_bound, (state_q == S_CP_WR) || (state_q == S_GC_WR),
		32'(k_q) < NUM_DIMS, "copy counter ran past the last dimension")
	`PSUE_ASSERT_NEXT(a_scan_monotone, state_q == S_SC_CMP, gbf_q <= $past(gbf_q),
		"scan raised the global best fitness")

endmodule
`default_nettype wire
